// File: design/tfn_pkg.sv
// Shared definitions for the triangle face normal unit.
// Holds the axis count, the result width and the per-transaction flag bundle.
// No dependencies.
`timescale 1ns / 1ps

package tfn_pkg;

   // Number of vector components (x, y, z).
   localparam int NUM_AXES = 3;

   // Width of each normal component on the result channel.
   localparam int NORMAL_WIDTH = 16;

   // Flags that travel alongside each transaction from the cross product stage on.
   typedef struct packed {
      logic [NUM_AXES-1:0] neg;  // Sign of each cross product component.
      logic                deg;  // Cross product is the zero vector.
   } flags_type;

endpackage

// File: design/tfn_front.sv
// Front end of the face normal pipeline: edges, cross product, squares, sum.
// Seven register stages with per-stage valid bits and a stall chain.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_front
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   localparam int MW = 2 * COORD_WIDTH + 1,
   localparam int QSW = 2 * MW,
   localparam int SW = QSW + 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  vert_a,
   input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  vert_b,
   input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  vert_c,
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output logic [NUM_AXES-1:0][QSW-1:0]          out_sq,
   output logic [SW-1:0]                         out_sum,
   output flags_type                             out_flags
);

   localparam int EW = COORD_WIDTH + 1;
   localparam int PW = 2 * EW;
   localparam int HW = (MW + 1) / 2;
   localparam int HH = MW - HW;
   localparam int NS = 7;

   // Stage valid bits and the stall chain from the output back to the input.
   logic [NS-1:0] v_ff, v_in, en;
   wire  [NS:0]   st_c;
   wire  [NS:0]   vs;

   assign st_c[NS] = out_stall;
   assign vs[0]    = in_valid;

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_flow
         assign st_c[k]   = v_ff[k] && st_c[k+1];
         assign vs[k+1]   = v_ff[k];
         assign en[k]     = !st_c[k];
         assign v_in[k]   = en[k] ? vs[k] : v_ff[k];
      end
   endgenerate

   assign in_stall  = st_c[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Stage registers.
   logic signed [EW-1:0]   e1_ff [NUM_AXES], e2_ff [NUM_AXES];
   logic signed [EW-1:0]   e1_in [NUM_AXES], e2_in [NUM_AXES];
   logic signed [PW-1:0]   p_ff [2*NUM_AXES], p_in [2*NUM_AXES];
   logic signed [PW-1:0]   n_ff [NUM_AXES], n_in [NUM_AXES];
   logic [MW-1:0]          m_ff [NUM_AXES], m_in [NUM_AXES];
   logic [2*HW-1:0]        ll_ff [NUM_AXES], ll_in [NUM_AXES];
   logic [MW-1:0]          hl_ff [NUM_AXES], hl_in [NUM_AXES];
   logic [2*HH-1:0]        hh_ff [NUM_AXES], hh_in [NUM_AXES];
   logic [QSW-1:0]         sq6_ff [NUM_AXES], sq6_in [NUM_AXES];
   logic [QSW-1:0]         sq7_ff [NUM_AXES];
   logic [SW-1:0]          sum_ff, sum_in;
   flags_type              f4_ff, f4_in, f5_ff, f6_ff, f7_ff;

   // Edge vectors, products, cross product and magnitudes.
   always_comb begin
      logic signed [PW-1:0] mabs;
      for (int i = 0; i < NUM_AXES; i++) begin
         e1_in[i] = {vert_b[i][COORD_WIDTH-1], vert_b[i]} - {vert_a[i][COORD_WIDTH-1], vert_a[i]};
         e2_in[i] = {vert_c[i][COORD_WIDTH-1], vert_c[i]} - {vert_a[i][COORD_WIDTH-1], vert_a[i]};
      end
      p_in[0] = e1_ff[1] * e2_ff[2];
      p_in[1] = e2_ff[1] * e1_ff[2];
      p_in[2] = e1_ff[2] * e2_ff[0];
      p_in[3] = e2_ff[2] * e1_ff[0];
      p_in[4] = e1_ff[0] * e2_ff[1];
      p_in[5] = e2_ff[0] * e1_ff[1];
      for (int i = 0; i < NUM_AXES; i++) begin
         n_in[i] = p_ff[2*i] - p_ff[2*i+1];
      end
      f4_in.deg = (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
      for (int i = 0; i < NUM_AXES; i++) begin
         f4_in.neg[i] = n_ff[i][PW-1];
         mabs = n_ff[i][PW-1] ? -n_ff[i] : n_ff[i];
         m_in[i] = mabs[MW-1:0];
      end
   end

   // Squares from three partial products, then the sum of squares.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         ll_in[i] = m_ff[i][HW-1:0] * m_ff[i][HW-1:0];
         hl_in[i] = m_ff[i][MW-1:HW] * m_ff[i][HW-1:0];
         hh_in[i] = m_ff[i][MW-1:HW] * m_ff[i][MW-1:HW];
         sq6_in[i] = (QSW'(hh_ff[i]) << (2 * HW)) + (QSW'(hl_ff[i]) << (HW + 1))
                     + QSW'(ll_ff[i]);
      end
      sum_in = SW'(sq6_ff[0]) + SW'(sq6_ff[1]) + SW'(sq6_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
      if (en[1]) begin
         p_ff <= p_in;
      end
      if (en[2]) begin
         n_ff <= n_in;
      end
      if (en[3]) begin
         m_ff  <= m_in;
         f4_ff <= f4_in;
      end
      if (en[4]) begin
         ll_ff <= ll_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
         f5_ff <= f4_ff;
      end
      if (en[5]) begin
         sq6_ff <= sq6_in;
         f6_ff  <= f5_ff;
      end
      if (en[6]) begin
         sq7_ff <= sq6_ff;
         sum_ff <= sum_in;
         f7_ff  <= f6_ff;
      end
   end

   // Outputs.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         out_sq[i] = sq7_ff[i];
      end
   end
   assign out_sum   = sum_ff;
   assign out_flags = f7_ff;

endmodule

// File: design/tfn_divide.sv
// Pipelined restoring divider: floor(square * 2^(2F) / sum) for each axis.
// One quotient bit per register stage, 2F+1 stages.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_divide
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int NORMAL_FRAC_BITS = 14,
   localparam int QSW = 2 * (2 * COORD_WIDTH + 1),
   localparam int SW = QSW + 2,
   localparam int QW = 2 * NORMAL_FRAC_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [NUM_AXES-1:0][QSW-1:0]  in_sq,
   input  logic [SW-1:0]                 in_sum,
   input  flags_type                     in_flags,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [NUM_AXES-1:0][QW-1:0]   out_quo,
   output flags_type                     out_flags
);

   localparam int ND = QW;

   // Stage valid bits and the stall chain.
   logic [ND-1:0] v_ff, v_in, en;
   wire  [ND:0]   st_c;
   wire  [ND:0]   vs;

   assign st_c[ND] = out_stall;
   assign vs[0]    = in_valid;

   genvar k;
   generate
      for (k = 0; k < ND; k++) begin : g_flow
         assign st_c[k] = v_ff[k] && st_c[k+1];
         assign vs[k+1] = v_ff[k];
         assign en[k]   = !st_c[k];
         assign v_in[k] = en[k] ? vs[k] : v_ff[k];
      end
   endgenerate

   assign in_stall  = st_c[0];
   assign out_valid = v_ff[ND-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Partial remainder, partial quotient, divisor and flags per stage.
   logic [SW-1:0] rem_ff [ND][NUM_AXES], rem_in [ND][NUM_AXES];
   logic [QW-1:0] quo_ff [ND][NUM_AXES], quo_in [ND][NUM_AXES];
   logic [SW-1:0] div_ff [ND], div_in [ND];
   flags_type     f_ff [ND], f_in [ND];

   // Each stage shifts in one bit and subtracts the divisor when it fits.
   always_comb begin
      logic [SW+1:0] r;
      logic [SW+1:0] diff;
      logic [QW-1:0] qp;
      logic          qbit;
      for (int s = 0; s < ND; s++) begin
         if (s == 0) begin
            div_in[s] = in_sum;
            f_in[s]   = in_flags;
         end else begin
            div_in[s] = div_ff[s-1];
            f_in[s]   = f_ff[s-1];
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            if (s == 0) begin
               r  = (SW+2)'(in_sq[i]);
               qp = '0;
            end else begin
               r  = {1'b0, rem_ff[s-1][i], 1'b0};
               qp = quo_ff[s-1][i];
            end
            diff = r - {2'b00, div_in[s]};
            qbit = !diff[SW+1];
            rem_in[s][i] = qbit ? diff[SW-1:0] : r[SW-1:0];
            quo_in[s][i] = {qp[QW-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < ND; s++) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            div_ff[s] <= div_in[s];
            f_ff[s]   <= f_in[s];
         end
      end
   end

   // Outputs.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         out_quo[i] = quo_ff[ND-1][i];
      end
   end
   assign out_flags = f_ff[ND-1];

endmodule

// File: design/tfn_sqrt.sv
// Pipelined integer square root of each quotient, one root bit per stage.
// The running square is updated incrementally, so no multiplier is needed.
// Depends on tfn_pkg.
`timescale 1ns / 1ps

module tfn_sqrt
   import tfn_pkg::*;
#(
   parameter int NORMAL_FRAC_BITS = 14,
   localparam int QW = 2 * NORMAL_FRAC_BITS + 1,
   localparam int RW = NORMAL_FRAC_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [NUM_AXES-1:0][QW-1:0]   in_val,
   input  flags_type                     in_flags,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [NUM_AXES-1:0][RW-1:0]   out_root,
   output flags_type                     out_flags
);

   localparam int NQ = RW;
   localparam int R2W = 2 * NORMAL_FRAC_BITS + 2;
   localparam int R2X = R2W + 1;

   // Stage valid bits and the stall chain.
   logic [NQ-1:0] v_ff, v_in, en;
   wire  [NQ:0]   st_c;
   wire  [NQ:0]   vs;

   assign st_c[NQ] = out_stall;
   assign vs[0]    = in_valid;

   genvar k;
   generate
      for (k = 0; k < NQ; k++) begin : g_flow
         assign st_c[k] = v_ff[k] && st_c[k+1];
         assign vs[k+1] = v_ff[k];
         assign en[k]   = !st_c[k];
         assign v_in[k] = en[k] ? vs[k] : v_ff[k];
      end
   endgenerate

   assign in_stall  = st_c[0];
   assign out_valid = v_ff[NQ-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Radicand, partial root and its square per stage.
   logic [QW-1:0]  val_ff [NQ][NUM_AXES], val_in [NQ][NUM_AXES];
   logic [RW-1:0]  r_ff [NQ][NUM_AXES], r_in [NQ][NUM_AXES];
   logic [R2W-1:0] r2_ff [NQ][NUM_AXES], r2_in [NQ][NUM_AXES];
   flags_type      f_ff [NQ], f_in [NQ];

   // Stage s tries root bit NORMAL_FRAC_BITS - s: (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b).
   always_comb begin
      logic [RW-1:0]  rp;
      logic [R2W-1:0] r2p;
      logic [R2X-1:0] t2;
      int             b;
      for (int s = 0; s < NQ; s++) begin
         b = NORMAL_FRAC_BITS - s;
         if (s == 0) begin
            f_in[s] = in_flags;
         end else begin
            f_in[s] = f_ff[s-1];
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            if (s == 0) begin
               val_in[s][i] = in_val[i];
               rp  = '0;
               r2p = '0;
            end else begin
               val_in[s][i] = val_ff[s-1][i];
               rp  = r_ff[s-1][i];
               r2p = r2_ff[s-1][i];
            end
            t2 = R2X'(r2p) + (R2X'(rp) << (b + 1)) + (R2X'(1) << (2 * b));
            if (t2 <= R2X'(val_in[s][i])) begin
               r_in[s][i]  = rp | (RW'(1) << b);
               r2_in[s][i] = t2[R2W-1:0];
            end else begin
               r_in[s][i]  = rp;
               r2_in[s][i] = r2p;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NQ; s++) begin
         if (en[s]) begin
            val_ff[s] <= val_in[s];
            r_ff[s]   <= r_in[s];
            r2_ff[s]  <= r2_in[s];
            f_ff[s]   <= f_in[s];
         end
      end
   end

   // Outputs.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         out_root[i] = r_ff[NQ-1][i];
      end
   end
   assign out_flags = f_ff[NQ-1];

endmodule

// File: design/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit.
// Instantiates tfn_front, tfn_divide and tfn_sqrt and holds the result register.
// Depends on tfn_pkg.
//
// Usage:
//   The request channel takes one triangle per transaction: vertices A, B, C as
//   signed Q8.8 coordinates. The response channel returns the unit normal of
//   (B - A) x (C - A) in signed Q1.14, each component truncated toward zero,
//   plus a degenerate flag. A zero cross product returns zeros with the flag set.
//   From acceptance to rsp_valid a transaction passes 7 front stages, one
//   divider stage per quotient bit (2F+1), one square root stage per root bit
//   (F+1) and the result register.
//   Throughput is one transaction per cycle while rsp_stall stays low; every stage has its own valid bit.
//   With rsp_valid and rsp_stall high the result register holds; stages behind it
//   keep filling bubbles until they reach a stage that holds a transaction;
//   req_stall rises only once the first stage is occupied and blocked.
//   Synchronous reset clears all valid bits; no transaction survives reset.
`timescale 1ns / 1ps

module triangle_face_normal_unit
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_WIDTH-1:0]        req_a_x,
   input  logic signed [COORD_WIDTH-1:0]        req_a_y,
   input  logic signed [COORD_WIDTH-1:0]        req_a_z,
   input  logic signed [COORD_WIDTH-1:0]        req_b_x,
   input  logic signed [COORD_WIDTH-1:0]        req_b_y,
   input  logic signed [COORD_WIDTH-1:0]        req_b_z,
   input  logic signed [COORD_WIDTH-1:0]        req_c_x,
   input  logic signed [COORD_WIDTH-1:0]        req_c_y,
   input  logic signed [COORD_WIDTH-1:0]        req_c_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [NORMAL_FRAC_BITS+1:0]   rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS+1:0]   rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS+1:0]   rsp_normal_z,
   output logic                                 rsp_degenerate
);

   localparam int MW  = 2 * COORD_WIDTH + 1;
   localparam int QSW = 2 * MW;
   localparam int SW  = QSW + 2;
   localparam int QW  = 2 * NORMAL_FRAC_BITS + 1;
   localparam int RW  = NORMAL_FRAC_BITS + 1;
   localparam int OW  = NORMAL_FRAC_BITS + 2;
   localparam int XW  = OW + 1;

   // Front end: edges, cross product and squared length.
   logic                          fr_valid, fr_stall;
   logic [NUM_AXES-1:0][QSW-1:0]  fr_sq;
   logic [SW-1:0]                 fr_sum;
   flags_type                     fr_flags;

   tfn_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .vert_a    ({req_a_z, req_a_y, req_a_x}),
      .vert_b    ({req_b_z, req_b_y, req_b_x}),
      .vert_c    ({req_c_z, req_c_y, req_c_x}),
      .out_valid (fr_valid),
      .out_stall (fr_stall),
      .out_sq    (fr_sq),
      .out_sum   (fr_sum),
      .out_flags (fr_flags)
   );

   // Divider: squared component over squared length, scaled by 2^(2F).
   logic                          dv_valid, dv_stall;
   logic [NUM_AXES-1:0][QW-1:0]   dv_quo;
   flags_type                     dv_flags;

   tfn_divide #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_stall  (fr_stall),
      .in_sq     (fr_sq),
      .in_sum    (fr_sum),
      .in_flags  (fr_flags),
      .out_valid (dv_valid),
      .out_stall (dv_stall),
      .out_quo   (dv_quo),
      .out_flags (dv_flags)
   );

   // Square root gives the magnitude of each normal component.
   logic                          sq_valid, sq_stall;
   logic [NUM_AXES-1:0][RW-1:0]   sq_root;
   flags_type                     sq_flags;

   tfn_sqrt #(
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_stall  (dv_stall),
      .in_val    (dv_quo),
      .in_flags  (dv_flags),
      .out_valid (sq_valid),
      .out_stall (sq_stall),
      .out_root  (sq_root),
      .out_flags (sq_flags)
   );

   // Result register: apply signs and force zeros for a degenerate triangle.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          load;
   logic [OW-1:0]                 nrm_ff [NUM_AXES], nrm_in [NUM_AXES];
   logic                          deg_ff;

   assign load     = !(rsp_valid_ff && rsp_stall);
   assign sq_stall = !load;
   assign rsp_valid_in = load ? sq_valid : rsp_valid_ff;

   always_comb begin
      logic signed [XW-1:0] mag_x;
      logic signed [XW-1:0] val_x;
      for (int i = 0; i < NUM_AXES; i++) begin
         mag_x = XW'(sq_root[i]);
         val_x = sq_flags.neg[i] ? -mag_x : mag_x;
         nrm_in[i] = sq_flags.deg ? '0 : val_x[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         nrm_ff <= nrm_in;
         deg_ff <= sq_flags.deg;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = nrm_ff[0];
   assign rsp_normal_y   = nrm_ff[1];
   assign rsp_normal_z   = nrm_ff[2];
   assign rsp_degenerate = deg_ff;

`ifndef NO_ASSERTIONS
   // A degenerate result carries an all-zero normal.
   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with nonzero normal");

   // A proper triangle always has at least one clearly nonzero component.
   a_nondeg_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
      else $error("nondegenerate result with zero normal");

   // The input side is blocked only while a result waits at the output.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // A stalled response register keeps its flag.
   a_hold_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_degenerate))
      else $error("response changed under stall");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for triangle_face_normal_unit.
// Predicts each unit normal in the testbench, compares the results in order, and
// varies idling on both channels. Depends on tfn_pkg and the design top level.
`timescale 1ns / 1ps

module tb_top
   import tfn_pkg::*;
();

   localparam int COORD_W = 16;
   localparam int FRAC_BITS = 14;
   localparam int LATENCY = 3 * FRAC_BITS + 10;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_PER_PHASE = 530;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
   } triangle_type;

   typedef struct packed {
      logic signed [NORMAL_WIDTH-1:0] nx, ny, nz;
      logic                           deg;
   } normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   triangle_type req_tri = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [NORMAL_WIDTH-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   normal_type expected_normals[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   triangle_face_normal_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_x(req_tri.ax), .req_a_y(req_tri.ay), .req_a_z(req_tri.az),
      .req_b_x(req_tri.bx), .req_b_y(req_tri.by), .req_b_z(req_tri.bz),
      .req_c_x(req_tri.cx), .req_c_y(req_tri.cy), .req_c_z(req_tri.cz),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact truncated unit normal: the largest q with q^2 * |N|^2 <= N_i^2 * 2^(2F).
   function automatic normal_type predict_normal(triangle_type t);
      longint e1x, e1y, e1z, e2x, e2y, e2z;
      longint n[3];
      longint mag_i;
      logic [127:0] len_sq, rhs, lhs, trial_sq;
      logic [15:0] q, trial;
      logic [15:0] comp[3];
      normal_type r;
      e1x = longint'(t.bx) - longint'(t.ax);
      e1y = longint'(t.by) - longint'(t.ay);
      e1z = longint'(t.bz) - longint'(t.az);
      e2x = longint'(t.cx) - longint'(t.ax);
      e2y = longint'(t.cy) - longint'(t.ay);
      e2z = longint'(t.cz) - longint'(t.az);
      n[0] = e1y * e2z - e2y * e1z;
      n[1] = e1z * e2x - e2z * e1x;
      n[2] = e1x * e2y - e2x * e1y;
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
         r = '0;
         r.deg = 1'b1;
         return r;
      end
      len_sq = '0;
      for (int i = 0; i < 3; i++) begin
         mag_i = (n[i] < 0) ? -n[i] : n[i];
         len_sq += 128'(mag_i) * 128'(mag_i);
      end
      for (int i = 0; i < 3; i++) begin
         mag_i = (n[i] < 0) ? -n[i] : n[i];
         rhs = (128'(mag_i) * 128'(mag_i)) << (2 * FRAC_BITS);
         q = '0;
         for (int b = FRAC_BITS; b >= 0; b--) begin
            trial = q | (16'd1 << b);
            trial_sq = 128'(trial) * 128'(trial);
            lhs = trial_sq * len_sq;
            if (lhs <= rhs) q = trial;
         end
         comp[i] = (n[i] < 0) ? -q : q;
      end
      r.nx = comp[0];
      r.ny = comp[1];
      r.nz = comp[2];
      r.deg = 1'b0;
      return r;
   endfunction

   // Present one triangle and hold it until the block takes it.
   task automatic send_triangle(triangle_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_tri <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_normals.push_back(predict_normal(t));
   endtask

   function automatic triangle_type tri_of(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz);
      triangle_type t;
      t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az);
      t.bx = 16'(bx); t.by = 16'(by); t.bz = 16'(bz);
      t.cx = 16'(cx); t.cy = 16'(cy); t.cz = 16'(cz);
      return t;
   endfunction

   function automatic logic [15:0] rand_coord(int spread);
      if (spread == 0) return 16'($urandom());
      return 16'($urandom_range(2 * spread) - spread);
   endfunction

   // Receiver stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Compare each result transaction against the oldest prediction.
   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_normals.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d z=%0d deg=%0b", $time,
                     rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate);
            error_count++;
         end else begin
            want = expected_normals.pop_front();
            if (rsp_normal_x !== want.nx || rsp_normal_y !== want.ny ||
                rsp_normal_z !== want.nz || rsp_degenerate !== want.deg) begin
               $display("%0t: expected x=%0d y=%0d z=%0d deg=%0b, actual x=%0d y=%0d z=%0d deg=%0b",
                        $time, want.nx, want.ny, want.nz, want.deg,
                        rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles where neither channel accepts a transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** triangle_face_normal_unit: FAILED **");
         $finish;
      end
   end

   // Extremes, axis-aligned normals, every sign and degenerate triangles.
   task automatic test_directed();
      send_triangle(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(tri_of(100, -5, 7, 100, -5, 7, 100, -5, 7));
      send_triangle(tri_of(0, 0, 0, 256, 256, 256, 512, 512, 512));
      send_triangle(tri_of(0, 0, 0, 256, 0, 0, 0, 256, 0));
      send_triangle(tri_of(0, 0, 0, 0, 256, 0, 256, 0, 0));
      send_triangle(tri_of(0, 0, 0, 0, 256, 0, 0, 0, 256));
      send_triangle(tri_of(0, 0, 0, 0, 0, 256, 0, 256, 0));
      send_triangle(tri_of(0, 0, 0, 0, 0, 256, 256, 0, 0));
      send_triangle(tri_of(0, 0, 0, 256, 0, 0, 0, 0, 256));
      send_triangle(tri_of(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768));
      send_triangle(tri_of(32767, 32767, 32767, -32768, 32767, 32767,
                           32767, -32768, 32767));
      send_triangle(tri_of(-32768, 32767, -32768, 32767, -32768, 32767,
                           -32768, -32768, 32767));
      send_triangle(tri_of(32767, -32768, 32767, -32768, 32767, -32768,
                           32767, 32767, -32768));
      send_triangle(tri_of(-32768, -32768, -32768, 32767, 32767, 32767,
                           -32768, -32768, -32768));
      send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
      send_triangle(tri_of(0, 0, 0, 1, 1, 1, 1, -1, 0));
      send_triangle(tri_of(10, 20, 30, -40, 50, -60, 70, -80, 90));
      send_triangle(tri_of(-1, -1, -1, 32767, 0, -32768, 0, 32767, 1));
      send_triangle(tri_of(0, 0, 0, 3, 4, 0, 6, 8, 1));
      send_triangle(tri_of(-32768, 0, 0, 32767, 0, 0, 0, 0, 0));
   endtask

   // Random triangles: full range, small spreads, collinear sets and perturbed collinear sets.
   task automatic test_random(int count);
      triangle_type t;
      int kind, k;
      logic signed [15:0] dx, dy, dz;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         if (kind < 5) begin
            t = {rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
                 rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0)};
         end else if (kind < 8) begin
            k = (kind == 5) ? 2 : 300;
            t = {rand_coord(k), rand_coord(k), rand_coord(k), rand_coord(k), rand_coord(k),
                 rand_coord(k), rand_coord(k), rand_coord(k), rand_coord(k)};
         end else begin
            // Collinear or coincident vertices: C = A + 2(B - A) within range; kind 9 then sets B.x to A.x.
            dx = rand_coord(4000);
            dy = rand_coord(4000);
            dz = rand_coord(4000);
            t.ax = rand_coord(16000);
            t.ay = rand_coord(16000);
            t.az = rand_coord(16000);
            t.bx = t.ax + dx; t.by = t.ay + dy; t.bz = t.az + dz;
            t.cx = t.bx + dx; t.cy = t.by + dy; t.cz = t.bz + dz;
            if (kind == 9) t.bx = t.ax;
         end
         send_triangle(t);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 6;
      recv_stall_pct = 51;
      test_directed();
      test_random(RANDOM_PER_PHASE);
      send_idle_pct = 51;
      recv_stall_pct = 6;
      test_random(RANDOM_PER_PHASE);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random(RANDOM_PER_PHASE);
      req_valid <= 1'b0;
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0) $display("** triangle_face_normal_unit: PASSED **");
      else $display("** triangle_face_normal_unit: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
design/tfn_pkg.sv
design/tfn_front.sv
design/tfn_divide.sv
design/tfn_sqrt.sv
design/triangle_face_normal_unit.sv
test/tb_top.sv
